### src/imm_pkg.sv
// Shared constants, types and helper functions for the integer matrix multiplier.
package imm_pkg;

    // Largest matrix dimension held in the element stores.
    localparam int MAX_DIM = 4;

    // Derived widths.
    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);

    // Fixed field widths of the stream and register interfaces.
    localparam int MODE_W      = 2;
    localparam int FIELD_IDX_W = 2;
    localparam int ELEM_W      = 16;
    localparam int ACC_W       = 32;
    localparam int CFG_W       = 3;
    localparam int S_DATA_W    = 24;
    localparam int M_DATA_W    = 40;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Item kinds carried in the input tuser field.
    localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_START  = 2'd2;

    // Register indexes.
    localparam logic REG_ACTIVE_ROWS = 1'b0;
    localparam logic REG_ACTIVE_COLS = 1'b1;

    // Bookkeeping that travels beside each read of the stores.
    typedef struct packed {
        logic             first;
        logic             last_k;
        logic             last_entry;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
    } rd_tag_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              wr_a;
        logic              wr_b;
        logic [ADDR_W-1:0] waddr;
        logic              rd_en;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
        rd_tag_t           tag;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic free;
    } dp_status_t;

    // Row-major address of an element.
    function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] row,
                                                    input logic [IDX_W-1:0] col);
        elem_addr = ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col);
    endfunction

    // A dimension register saturates at the store size.
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] value);
        if (int'(value) > MAX_DIM)
            clamp_dim = DIM_W'(MAX_DIM);
        else
            clamp_dim = DIM_W'(value);
    endfunction

endpackage

### src/imm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module imm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem_reg[raddr];
    end

endmodule

### src/imm_dp.sv
// Datapath: element stores, multiplier, accumulator and output register.
module imm_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  imm_pkg::dp_cmd_t                    cmd,
    input  logic [imm_pkg::ELEM_W-1:0]          wdata,
    output imm_pkg::dp_status_t                 status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [imm_pkg::FIELD_IDX_W-1:0]     out_row,
    output logic [imm_pkg::FIELD_IDX_W-1:0]     out_col,
    output logic [imm_pkg::ACC_W-1:0]           out_value,
    output logic                                out_last
);
    import imm_pkg::*;

    logic [ELEM_W-1:0] a_rdata;
    logic [ELEM_W-1:0] b_rdata;

    logic              s1_v_reg, s1_v_next;
    rd_tag_t           s1_tag_reg;
    logic              s2_v_reg, s2_v_next;
    rd_tag_t           s2_tag_reg;
    logic signed [ACC_W-1:0] prod_reg, prod_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  sum;

    logic              out_v_reg, out_v_next;
    logic [FIELD_IDX_W-1:0] out_row_reg, out_col_reg;
    logic [ACC_W-1:0]  out_value_reg;
    logic              out_last_reg;

    // Element stores for A and B.
    imm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_a (
        .clk   (clk),
        .we    (cmd.wr_a),
        .waddr (cmd.waddr),
        .wdata (wdata),
        .raddr (cmd.raddr_a),
        .rdata (a_rdata)
    );

    imm_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_b (
        .clk   (clk),
        .we    (cmd.wr_b),
        .waddr (cmd.waddr),
        .wdata (wdata),
        .raddr (cmd.raddr_b),
        .rdata (b_rdata)
    );

    // Signed product of the two elements read in the previous cycle.
    assign prod_next = ACC_W'($signed(a_rdata)) * ACC_W'($signed(b_rdata));

    // Accumulate, restarting on the first term of each entry.
    assign sum      = (s2_tag_reg.first ? '0 : acc_reg) + prod_reg;
    assign acc_next = s2_v_reg ? sum : acc_reg;

    // Pipeline valid bits and the output slot.
    always_comb
    begin
        s1_v_next  = cmd.rd_en;
        s2_v_next  = s1_v_reg;
        out_v_next = out_v_reg;
        if (out_v_reg && out_ready)
            out_v_next = 1'b0;
        if (s2_v_reg && s2_tag_reg.last_k)
            out_v_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg  <= s1_v_next;
            s2_v_reg  <= s2_v_next;
            out_v_reg <= out_v_next;
        end
    end

    // Payload registers of the pipeline.
    always_ff @(posedge clk)
    begin
        s1_tag_reg <= cmd.tag;
        s2_tag_reg <= s1_tag_reg;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        if (s2_v_reg && s2_tag_reg.last_k)
        begin
            out_row_reg   <= FIELD_IDX_W'(s2_tag_reg.row);
            out_col_reg   <= FIELD_IDX_W'(s2_tag_reg.col);
            out_value_reg <= sum;
            out_last_reg  <= s2_tag_reg.last_entry;
        end
    end

    // The controller may start a new entry only when nothing is in flight.
    assign status.free = !s1_v_reg && !s2_v_reg && !out_v_reg;

    assign out_valid = out_v_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign out_value = out_value_reg;
    assign out_last  = out_last_reg;

endmodule

### src/imm_ctrl.sv
// Controller: decodes input items and walks the multiply-accumulate loop.
module imm_ctrl (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [imm_pkg::MODE_W-1:0]        mode,
    input  logic [imm_pkg::FIELD_IDX_W-1:0]   row_index,
    input  logic [imm_pkg::FIELD_IDX_W-1:0]   col_index,
    input  logic [imm_pkg::CFG_W-1:0]         active_rows,
    input  logic [imm_pkg::CFG_W-1:0]         active_cols,
    input  imm_pkg::dp_status_t               status,
    output imm_pkg::dp_cmd_t                  cmd
);
    import imm_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             state_reg, state_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [IDX_W-1:0] k_reg, k_next;

    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    logic             accept;
    logic             idx_ok;
    logic             issue;
    logic             k_last;
    logic             j_last;
    logic             i_last;

    assign rows   = clamp_dim(active_rows);
    assign cols   = clamp_dim(active_cols);
    assign accept = in_valid && in_ready;
    assign idx_ok = (int'(row_index) < MAX_DIM) && (int'(col_index) < MAX_DIM);

    assign k_last = (DIM_W'(k_reg) == cols - DIM_W'(1));
    assign j_last = (DIM_W'(j_reg) == cols - DIM_W'(1));
    assign i_last = (DIM_W'(i_reg) == rows - DIM_W'(1));

    // A new entry starts only once the previous one has left the datapath.
    assign issue = (state_reg == ST_RUN) && ((k_reg != '0) || status.free);

    assign in_ready = (state_reg == ST_IDLE);

    // Command generation.
    always_comb
    begin
        cmd                = '0;
        cmd.waddr          = elem_addr(IDX_W'(row_index), IDX_W'(col_index));
        cmd.raddr_a        = elem_addr(i_reg, k_reg);
        cmd.raddr_b        = elem_addr(k_reg, j_reg);
        cmd.rd_en          = issue;
        cmd.tag.first      = (k_reg == '0);
        cmd.tag.last_k     = k_last;
        cmd.tag.last_entry = i_last && j_last;
        cmd.tag.row        = i_reg;
        cmd.tag.col        = j_reg;
        if (accept && idx_ok)
        begin
            cmd.wr_a = (mode == MODE_LOAD_A);
            cmd.wr_b = (mode == MODE_LOAD_B);
        end
    end

    // State machine and loop counters.
    always_comb
    begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && mode == MODE_START && rows != '0 && cols != '0)
                begin
                    state_next = ST_RUN;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    if (!k_last)
                        k_next = k_reg + IDX_W'(1);
                    else
                    begin
                        k_next = '0;
                        if (!j_last)
                            j_next = j_reg + IDX_W'(1);
                        else
                        begin
                            j_next = '0;
                            if (!i_last)
                                i_next = i_reg + IDX_W'(1);
                            else
                                state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

endmodule

### src/integer_matrix_multiply.sv
// Top level of the integer matrix multiplier: register port, controller and datapath.
// A load transfer is taken while the controller is idle, and loads may follow back
// to back. A start transfer produces rows*cols entries; each entry reads cols terms
// from the stores through the single multiply-accumulate unit, and a new entry starts
// only once the previous one has left the pipeline and the output slot.
// Reset (rst_n, asynchronous, active low) sets both dimension registers to 4 and
// idles the controller; the element stores hold no defined value until loaded.
module integer_matrix_multiply (
    input  logic                               clk,
    input  logic                               rst_n,
    // Input stream.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // s_tdata: row_index[1:0], col_index[3:2], element_value[19:4], zero pad [23:20].
    input  logic [imm_pkg::S_DATA_W-1:0]       s_tdata,
    // s_tuser: mode[1:0].
    input  logic [imm_pkg::MODE_W-1:0]         s_tuser,
    // Output stream.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // m_tdata: out_row[1:0], out_col[3:2], product_value[35:4], zero pad [39:36].
    output logic [imm_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tlast,
    // Register port.
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [imm_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [imm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [imm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);
    import imm_pkg::*;

    logic [CFG_W-1:0] active_rows_reg, active_rows_next;
    logic [CFG_W-1:0] active_cols_reg, active_cols_next;
    logic             reg_wr;
    logic             reg_sel;

    dp_cmd_t          cmd;
    dp_status_t       status;

    logic [FIELD_IDX_W-1:0] out_row;
    logic [FIELD_IDX_W-1:0] out_col;
    logic [ACC_W-1:0]       out_value;

    // Register port: writes complete in the access phase, reads are immediate.
    assign pready  = 1'b1;
    assign reg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_comb
    begin
        active_rows_next = active_rows_reg;
        active_cols_next = active_cols_reg;
        if (reg_wr)
        begin
            unique case (reg_sel)
                REG_ACTIVE_ROWS: active_rows_next = pwdata[CFG_W-1:0];
                REG_ACTIVE_COLS: active_cols_next = pwdata[CFG_W-1:0];
                default:         active_rows_next = active_rows_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ACTIVE_ROWS: prdata = APB_DATA_W'(active_rows_reg);
            REG_ACTIVE_COLS: prdata = APB_DATA_W'(active_cols_reg);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_rows_reg <= CFG_W'(4);
            active_cols_reg <= CFG_W'(4);
        end
        else
        begin
            active_rows_reg <= active_rows_next;
            active_cols_reg <= active_cols_next;
        end
    end

    // Controller.
    imm_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .mode        (s_tuser),
        .row_index   (s_tdata[1:0]),
        .col_index   (s_tdata[3:2]),
        .active_rows (active_rows_reg),
        .active_cols (active_cols_reg),
        .status      (status),
        .cmd         (cmd)
    );

    // Datapath.
    imm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .wdata     (s_tdata[19:4]),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .out_last  (m_tlast)
    );

    // Pack the result transfer.
    assign m_tdata = {4'b0000, out_value, out_col, out_row};

endmodule
